### rtl/cfb_pkg.sv
`timescale 1ns / 1ps

package cfb_pkg;

	localparam int OP_W    = 3;
	localparam int FIELD_W = 16;
	localparam int COLOR_W = 16;
	localparam int COUNT_W = 17;

	// drawing command codes; six and seven are unused
	typedef enum logic [OP_W-1:0] {
		OP_PIXEL = 3'd0,
		OP_RECT  = 3'd1,
		OP_CLEAR = 3'd2,
		OP_BEGIN = 3'd3,
		OP_IMAGE = 3'd4,
		OP_READ  = 3'd5
	} op_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture an input word
		logic boot;      // set up the clearing pass after reset
		logic mul;       // form the row base address and clipped sizes
		logic add;       // form the start address
		logic exec;      // do a command that needs no fill
		logic fill;      // write one pixel of a fill and advance
		logic res_load;  // capture the result word
	} cfb_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic fill_go;   // command covers a rectangle of pixels
		logic fill_last; // current fill pixel is the last one
	} cfb_stat_t;

endpackage

### rtl/cfb_ctrl.sv
`timescale 1ns / 1ps

module cfb_ctrl import cfb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  cfb_stat_t stat,
	output cfb_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_BOOT,
		S_IDLE,
		S_MUL,
		S_ADD,
		S_EXEC,
		S_FILL,
		S_FIN
	} state_t;

	state_t state_q;
	logic   boot_q;
	logic   out_valid_q;

	// decode commands from state
	always_comb begin
		cmd          = '0;
		cmd.boot     = (state_q == S_BOOT);
		cmd.load     = (state_q == S_IDLE) && in_valid;
		cmd.mul      = (state_q == S_MUL);
		cmd.add      = (state_q == S_ADD);
		cmd.exec     = (state_q == S_EXEC);
		cmd.fill     = (state_q == S_FILL);
		cmd.res_load = (state_q == S_FIN) && (!out_valid_q || out_ready);
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// sequence each word and hold the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_BOOT;
			boot_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_BOOT: begin
					state_q <= S_MUL;
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					state_q <= stat.fill_go ? S_FILL : S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_FIN;
				end
				S_FILL: begin
					if (stat.fill_last) begin
						// the clearing pass after reset gives no result
						if (boot_q) begin
							boot_q  <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/cfb_datapath.sv
`timescale 1ns / 1ps

module cfb_datapath import cfb_pkg::*; #(
	parameter int SCREEN_COLUMNS = 320,
	parameter int SCREEN_ROWS    = 240
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfb_cmd_t           cmd,
	output cfb_stat_t          stat,
	input  logic [OP_W-1:0]    operation,
	input  logic [FIELD_W-1:0] x_pos,
	input  logic [FIELD_W-1:0] y_pos,
	input  logic [FIELD_W-1:0] rect_width,
	input  logic [FIELD_W-1:0] rect_height,
	input  logic [COLOR_W-1:0] color,
	output logic [COLOR_W-1:0] read_color,
	output logic [COUNT_W-1:0] pixels_written
);

	localparam int DEPTH = SCREEN_COLUMNS * SCREEN_ROWS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int XW    = (SCREEN_COLUMNS > 1) ? $clog2(SCREEN_COLUMNS) : 1;
	localparam int YW    = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
	localparam int CW    = $clog2(SCREEN_COLUMNS + 1);
	localparam int RW    = $clog2(SCREEN_ROWS + 1);

	localparam logic [FIELD_W-1:0] COLS_F = FIELD_W'(SCREEN_COLUMNS);
	localparam logic [FIELD_W-1:0] ROWS_F = FIELD_W'(SCREEN_ROWS);
	localparam logic [AW-1:0]      COLS_A = AW'(SCREEN_COLUMNS);

	// captured word
	op_t                op_q;
	logic [FIELD_W-1:0] x_q;
	logic [FIELD_W-1:0] y_q;
	logic [FIELD_W-1:0] w_q;
	logic [FIELD_W-1:0] h_q;
	logic [COLOR_W-1:0] color_q;

	// address and fill walk
	logic [AW-1:0]      row_base_q;
	logic [AW-1:0]      addr_q;
	logic [AW-1:0]      line_q;
	logic [CW-1:0]      cw_q;
	logic [RW-1:0]      ch_q;
	logic [CW-1:0]      fc_q;
	logic [RW-1:0]      fr_q;
	logic [COUNT_W-1:0] count_q;

	// open image
	logic               img_active_q;
	logic [XW-1:0]      img_left_q;
	logic [YW-1:0]      img_top_q;
	logic [FIELD_W-1:0] img_stride_q;
	logic [CW-1:0]      img_cw_q;
	logic [RW-1:0]      img_ch_q;
	logic [FIELD_W-1:0] img_col_q;
	logic [RW-1:0]      img_row_q;

	// frame store
	logic [COLOR_W-1:0] mem [DEPTH];
	logic [COLOR_W-1:0] rd_q;
	logic               we;

	// result
	logic [COLOR_W-1:0] res_color_q;
	logic [COUNT_W-1:0] res_count_q;

	logic               on_scr;
	logic               rect_ok;
	logic [FIELD_W-1:0] rem_x;
	logic [FIELD_W-1:0] rem_y;
	logic [CW-1:0]      clip_w;
	logic [RW-1:0]      clip_h;
	logic [XW-1:0]      eff_x;
	logic [YW-1:0]      eff_y;
	logic               img_hit;
	logic [FIELD_W:0]   col_nx;
	logic [RW-1:0]      row_nx;
	logic               last_col;

	// screen tests and clipping to the screen edge
	always_comb begin
		on_scr  = (x_q < COLS_F) && (y_q < ROWS_F);
		rect_ok = on_scr && (w_q != '0) && (h_q != '0);
		rem_x   = COLS_F - x_q;
		rem_y   = ROWS_F - y_q;
		clip_w  = CW'((w_q > rem_x) ? rem_x : w_q);
		clip_h  = RW'((h_q > rem_y) ? rem_y : h_q);
	end

	// pick the pixel coordinates for this command
	always_comb begin
		case (op_q)
			OP_CLEAR: begin
				eff_x = '0;
				eff_y = '0;
			end
			OP_IMAGE: begin
				eff_x = XW'(img_left_q + img_col_q[XW-1:0]);
				eff_y = YW'(RW'(img_top_q) + img_row_q);
			end
			default: begin
				eff_x = x_q[XW-1:0];
				eff_y = y_q[YW-1:0];
			end
		endcase
	end

	always_comb begin
		img_hit  = img_active_q && (img_col_q < FIELD_W'(img_cw_q)) && (img_row_q < img_ch_q);
		col_nx   = {1'b0, img_col_q} + (FIELD_W+1)'(1);
		row_nx   = img_row_q + RW'(1);
		last_col = (fc_q == cw_q - CW'(1));
	end

	assign stat.fill_go   = (op_q == OP_CLEAR) || ((op_q == OP_RECT) && rect_ok);
	assign stat.fill_last = last_col && (fr_q == ch_q - RW'(1));

	// write enable for the frame store
	always_comb begin
		we = 1'b0;
		if (cmd.fill) begin
			we = 1'b1;
		end else if (cmd.exec) begin
			case (op_q)
				OP_PIXEL: we = on_scr;
				OP_IMAGE: we = img_hit;
				default:  we = 1'b0;
			endcase
		end
	end

	// frame store with registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr_q] <= color_q;
		end
		rd_q <= mem[addr_q];
	end

	// capture the word, walk addresses, count writes
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op_t'(operation);
			x_q     <= x_pos;
			y_q     <= y_pos;
			w_q     <= rect_width;
			h_q     <= rect_height;
			color_q <= color;
			count_q <= '0;
		end
		if (cmd.boot) begin
			op_q    <= OP_CLEAR;
			color_q <= '0;
			count_q <= '0;
		end
		if (cmd.mul) begin
			row_base_q <= AW'(eff_y) * COLS_A;
			if (op_q == OP_CLEAR) begin
				cw_q <= CW'(SCREEN_COLUMNS);
				ch_q <= RW'(SCREEN_ROWS);
			end else begin
				cw_q <= clip_w;
				ch_q <= clip_h;
			end
		end
		if (cmd.add) begin
			addr_q <= row_base_q + AW'(eff_x);
			line_q <= row_base_q + AW'(eff_x);
			fc_q   <= '0;
			fr_q   <= '0;
		end
		if (cmd.exec && we) begin
			count_q <= COUNT_W'(1);
		end
		if (cmd.fill) begin
			count_q <= count_q + COUNT_W'(1);
			if (last_col) begin
				fc_q   <= '0;
				fr_q   <= fr_q + RW'(1);
				line_q <= line_q + COLS_A;
				addr_q <= line_q + COLS_A;
			end else begin
				fc_q   <= fc_q + CW'(1);
				addr_q <= addr_q + AW'(1);
			end
		end
		if (cmd.res_load) begin
			res_color_q <= ((op_q == OP_READ) && on_scr) ? rd_q : '0;
			res_count_q <= count_q;
		end
	end

	// open, advance and close the image
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_active_q <= 1'b0;
		end else if (cmd.exec) begin
			if (op_q == OP_BEGIN) begin
				img_active_q <= rect_ok;
			end else if ((op_q == OP_IMAGE) && img_active_q &&
					(col_nx >= {1'b0, img_stride_q}) && (row_nx >= img_ch_q)) begin
				img_active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (op_q == OP_BEGIN) begin
				img_left_q   <= x_q[XW-1:0];
				img_top_q    <= y_q[YW-1:0];
				img_stride_q <= w_q;
				img_col_q    <= '0;
				img_row_q    <= '0;
				img_cw_q     <= rect_ok ? clip_w : '0;
				img_ch_q     <= rect_ok ? clip_h : '0;
			end else if ((op_q == OP_IMAGE) && img_active_q) begin
				if (col_nx >= {1'b0, img_stride_q}) begin
					img_col_q <= '0;
					img_row_q <= row_nx;
				end else begin
					img_col_q <= col_nx[FIELD_W-1:0];
				end
			end
		end
	end

	assign read_color     = res_color_q;
	assign pixels_written = res_count_q;

endmodule

### rtl/clipped_framebuffer_drawing_top.sv
`timescale 1ns / 1ps
// Channel | Handshake            | Payload
// input   | in_valid / in_ready  | operation, x_pos, y_pos, rect_width, rect_height, color
// output  | out_valid / out_ready| read_color, pixels_written
//
// Pixel write, image pixel, read, begin image and unused codes pass through
// states MUL, ADD, EXEC and FIN. Rect fill and clear pass through MUL, ADD,
// FILL (one store write a cycle) and FIN; a fill that covers nothing takes
// the EXEC path. After reset a clearing pass writes black to the whole store,
// with in_ready low throughout.
// The result register lets the next word enter while a result waits for out_ready;
// a word holds in its last cycle while the previous result is still waiting.

module clipped_framebuffer_drawing_top import cfb_pkg::*; #(
	parameter int SCREEN_COLUMNS = 320,
	parameter int SCREEN_ROWS    = 240
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [OP_W-1:0]    operation,
	input  logic [FIELD_W-1:0] x_pos,
	input  logic [FIELD_W-1:0] y_pos,
	input  logic [FIELD_W-1:0] rect_width,
	input  logic [FIELD_W-1:0] rect_height,
	input  logic [COLOR_W-1:0] color,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [COLOR_W-1:0] read_color,
	output logic [COUNT_W-1:0] pixels_written
);

	cfb_cmd_t  cmd;
	cfb_stat_t stat;

	// sequence each word
	cfb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// frame store, address walk and image state
	cfb_datapath #(
		.SCREEN_COLUMNS (SCREEN_COLUMNS),
		.SCREEN_ROWS    (SCREEN_ROWS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.operation      (operation),
		.x_pos          (x_pos),
		.y_pos          (y_pos),
		.rect_width     (rect_width),
		.rect_height    (rect_height),
		.color          (color),
		.read_color     (read_color),
		.pixels_written (pixels_written)
	);

endmodule
